FILE: src/tgr_pkg.sv
// Touch gesture recognizer: shared types, codes and constants.
// Used by the controller, the datapath and the top level.
package tgr_pkg;

    typedef enum logic [2:0] {
        M_NONE, M_HOLDING, M_HELD, M_TAPPED, M_FREE, M_HORIZ, M_VERT, M_PINCH
    } mode_t;

    typedef enum logic [1:0] {K_PRESS, K_RELEASE, K_MOVE, K_UPDATE} kind_t;

    typedef enum logic [3:0] {
        C_IDLE, C_SCAN, C_MUL, C_CMP, C_DLOAD, C_DIV, C_DBLEND, C_DFIN, C_EXEC, C_EMIT
    } ctl_state_t;

    localparam logic [3:0] G_TAP       = 4'd0;
    localparam logic [3:0] G_DTAP      = 4'd1;
    localparam logic [3:0] G_HOLD      = 4'd2;
    localparam logic [3:0] G_HDRAG     = 4'd3;
    localparam logic [3:0] G_VDRAG     = 4'd4;
    localparam logic [3:0] G_FDRAG     = 4'd5;
    localparam logic [3:0] G_PINCH     = 4'd6;
    localparam logic [3:0] G_FLICK     = 4'd7;
    localparam logic [3:0] G_DRAGDONE  = 4'd8;
    localparam logic [3:0] G_PINCHDONE = 4'd9;

    localparam logic [2:0] CFG_MASK   = 3'd0;
    localparam logic [2:0] CFG_THR    = 3'd1;
    localparam logic [2:0] CFG_DTAP   = 3'd2;
    localparam logic [2:0] CFG_HOLD   = 3'd3;
    localparam logic [2:0] CFG_FLICK  = 3'd4;

    localparam logic [7:0] NONE_ID    = 8'hFF;
    localparam int         DIV_STEPS  = 35;
    localparam logic [34:0] VEL_SCALE = 35'd256000;
    localparam logic [6:0]  VEL_ALPHA = 7'd115;

    typedef struct packed {
        logic [3:0]  gesture;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] fdx;
        logic [15:0] fdy;
        logic [15:0] sdx;
        logic [15:0] sdy;
        logic [7:0]  ff;
        logic [7:0]  sf;
        logic        last;
    } res_t;

    typedef struct packed {
        logic       latch;
        logic       scan_step;
        logic       mul;
        logic       cmp;
        logic       dload;
        logic       div_step;
        logic       dblend;
        logic       dfin;
        logic       axis;
        logic       exec;
        logic       emit;
        logic [1:0] emit_idx;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic       scan_done;
        logic       need_div;
        logic [1:0] res_n;
        logic       out_free;
    } sts_t;

    function automatic res_t mk_res(logic [3:0] g, logic [15:0] fx, logic [15:0] fy,
                                    logic [15:0] sx, logic [15:0] sy,
                                    logic [15:0] fdx, logic [15:0] fdy,
                                    logic [15:0] sdx, logic [15:0] sdy,
                                    logic [7:0] ff, logic [7:0] sf);
        res_t r;
        r.gesture = g;
        r.fx = fx; r.fy = fy; r.sx = sx; r.sy = sy;
        r.fdx = fdx; r.fdy = fdy; r.sdx = sdx; r.sdy = sdy;
        r.ff = ff; r.sf = sf;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

FILE: src/tgr_if.sv
// Touch gesture recognizer: event, result and configuration channel interfaces.
// Depends on nothing; payload widths are fixed by the field definitions.
interface tgr_evt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         finger_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [31:0]        now_ms;
    modport source (output valid, kind, finger_id, pos_x, pos_y, delta_x, delta_y, now_ms,
                    input ready);
    modport sink (input valid, kind, finger_id, pos_x, pos_y, delta_x, delta_y, now_ms,
                  output ready);
endinterface

interface tgr_res_if;
    logic               valid;
    logic               ready;
    logic [3:0]         gesture;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [15:0] first_dx;
    logic signed [15:0] first_dy;
    logic signed [15:0] second_dx;
    logic signed [15:0] second_dy;
    logic [7:0]         first_finger;
    logic [7:0]         second_finger;
    logic               last;
    modport source (output valid, gesture, first_x, first_y, second_x, second_y, first_dx,
                    first_dy, second_dx, second_dy, first_finger, second_finger, last,
                    input ready);
    modport sink (input valid, gesture, first_x, first_y, second_x, second_y, first_dx,
                  first_dy, second_dx, second_dy, first_finger, second_finger, last,
                  output ready);
endinterface

interface tgr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tgr_ctrl.sv
// Touch gesture recognizer: sequencing state machine.
// Depends on tgr_pkg; drives the datapath by cmd_t and watches sts_t.
module tgr_ctrl
    import tgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    ctl_state_t state_reg, state_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic       axis_reg, axis_next;
    logic [1:0] emit_j_reg, emit_j_next;
    logic       emit_last;

    assign emit_last = (emit_j_reg == sts.res_n - 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            div_cnt_reg <= '0;
            axis_reg   <= 1'b0;
            emit_j_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            div_cnt_reg <= div_cnt_next;
            axis_reg   <= axis_next;
            emit_j_reg <= emit_j_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        axis_next    = axis_reg;
        emit_j_next  = emit_j_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                    state_next = C_SCAN;
            end
            C_SCAN:
            begin
                if (sts.kind != K_RELEASE || sts.scan_done)
                    state_next = C_MUL;
            end
            C_MUL:
                state_next = C_CMP;
            C_CMP:
            begin
                axis_next = 1'b0;
                state_next = sts.need_div ? C_DLOAD : C_EXEC;
            end
            C_DLOAD:
            begin
                div_cnt_next = '0;
                state_next = C_DIV;
            end
            C_DIV:
            begin
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DIV_STEPS - 1))
                    state_next = C_DBLEND;
            end
            C_DBLEND:
                state_next = C_DFIN;
            C_DFIN:
            begin
                axis_next = 1'b1;
                state_next = axis_reg ? C_EXEC : C_DLOAD;
            end
            C_EXEC:
            begin
                emit_j_next = '0;
                state_next = C_EMIT;
            end
            C_EMIT:
            begin
                if (sts.res_n == 2'd0)
                    state_next = C_IDLE;
                else if (sts.out_free)
                begin
                    emit_j_next = emit_j_reg + 2'd1;
                    if (emit_last)
                        state_next = C_IDLE;
                end
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.axis = axis_reg;
        cmd.emit_idx = emit_j_reg;
        cmd.emit_last = emit_last;
        in_ready = (state_reg == C_IDLE);
        unique case (state_reg)
            C_IDLE:   cmd.latch = in_valid;
            C_SCAN:   cmd.scan_step = (sts.kind == K_RELEASE) && !sts.scan_done;
            C_MUL:    cmd.mul = 1'b1;
            C_CMP:    cmd.cmp = 1'b1;
            C_DLOAD:  cmd.dload = 1'b1;
            C_DIV:    cmd.div_step = 1'b1;
            C_DBLEND: cmd.dblend = 1'b1;
            C_DFIN:   cmd.dfin = 1'b1;
            C_EXEC:   cmd.exec = 1'b1;
            C_EMIT:   cmd.emit = (sts.res_n != 2'd0) && sts.out_free;
            default:  cmd = cmd;
        endcase
    end

endmodule

FILE: src/tgr_dp.sv
// Touch gesture recognizer: datapath with gesture state, finger list, squared distance
// unit, serial velocity divider, result staging and output register. Depends on tgr_pkg.
module tgr_dp
    import tgr_pkg::*;
#(
    parameter int MAX_FINGERS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         in_kind,
    input  logic [7:0]         in_id,
    input  logic signed [15:0] in_x,
    input  logic signed [15:0] in_y,
    input  logic signed [15:0] in_dx,
    input  logic signed [15:0] in_dy,
    input  logic [31:0]        in_now,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               out_res
);

    localparam int CNT_W = $clog2(MAX_FINGERS + 1);
    localparam int IDX_W = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;

    // configuration
    logic [9:0]  mask_reg;
    logic [11:0] thr_reg;
    logic [15:0] dtap_win_reg, hold_reg, flick_reg;

    // latched item
    kind_t              it_kind;
    logic [7:0]         it_id;
    logic signed [15:0] it_x, it_y, it_dx, it_dy;
    logic [31:0]        it_now;

    // gesture state
    mode_t              mode_reg, mode_next;
    logic [7:0]         act_f_reg, act_f_next, sec_f_reg, sec_f_next;
    logic signed [15:0] act_x_reg, act_x_next, act_y_reg, act_y_next;
    logic signed [15:0] sec_x_reg, sec_x_next, sec_y_reg, sec_y_next;
    logic signed [15:0] prs_x_reg, prs_x_next, prs_y_reg, prs_y_next;
    logic signed [15:0] lup_x_reg, lup_x_next, lup_y_reg, lup_y_next;
    logic [31:0]        evt_t_reg, evt_t_next, upd_t_reg, upd_t_next;
    logic               utv_reg, utv_next, dtap_reg, dtap_next, bp_reg, bp_next;
    logic signed [23:0] vel_x_reg, vel_y_reg;
    logic               vel_clr;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               press_wr;

    // finger list and scan
    logic [7:0]         fingers_reg [MAX_FINGERS];
    logic [CNT_W-1:0]   scan_i_reg, keep_k_reg;
    logic               found_reg;
    logic [7:0]         cand_reg;
    logic [7:0]         cand_act, scan_e;

    // distance unit
    logic signed [16:0] pdx, pdy;
    logic [33:0]        sqa_reg, sqb_reg;
    logic [23:0]        thr2_reg;
    logic [47:0]        vx2_reg, vy2_reg, m2_reg;
    logic               near_reg, fast_reg;

    // velocity divider
    logic signed [16:0] dsel;
    logic [16:0]        dmag;
    logic [34:0]        num_reg;
    logic [32:0]        rem_reg, dvs_reg;
    logic               neg_reg;
    logic [33:0]        rem_sh;
    logic               rem_ge;
    logic signed [23:0] vel_sel;
    logic signed [24:0] inst;
    logic signed [31:0] prod_reg;
    logic signed [24:0] vsum;
    logic signed [23:0] vnew;

    // results
    res_t               stage_reg [3];
    res_t               stage_nx [3];
    logic [1:0]         stage_n_reg, stage_n_nx;
    logic               out_valid_reg;
    res_t               out_reg;

    assign cand_act = (it_id == act_f_reg) ? sec_f_reg : act_f_reg;
    assign scan_e   = fingers_reg[scan_i_reg[IDX_W-1:0]];

    assign sts.kind      = it_kind;
    assign sts.scan_done = (scan_i_reg == cnt_reg);
    assign sts.need_div  = (it_kind == K_UPDATE) && (mode_reg != M_PINCH) &&
                           (act_f_reg != NONE_ID) && mask_reg[G_FLICK] && utv_reg;
    assign sts.res_n     = stage_n_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            thr_reg      <= 12'd35;
            dtap_win_reg <= 16'd300;
            hold_reg     <= 16'd1000;
            flick_reg    <= 16'd100;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MASK:  mask_reg <= cfg_data[9:0];
                CFG_THR:   thr_reg <= cfg_data[11:0];
                CFG_DTAP:  dtap_win_reg <= cfg_data;
                CFG_HOLD:  hold_reg <= cfg_data;
                CFG_FLICK: flick_reg <= cfg_data;
                default:   mask_reg <= mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            it_kind <= kind_t'(in_kind);
            it_id   <= in_id;
            it_x    <= in_x;
            it_y    <= in_y;
            it_dx   <= in_dx;
            it_dy   <= in_dy;
            it_now  <= in_now;
        end
    end

    // Finger list: compact on release during the scan, append on press.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_e != it_id)
            fingers_reg[keep_k_reg[IDX_W-1:0]] <= scan_e;
        else if (cmd.exec && press_wr)
            fingers_reg[cnt_reg[IDX_W-1:0]] <= it_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_i_reg <= '0;
            keep_k_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.latch)
        begin
            scan_i_reg <= '0;
            keep_k_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_i_reg <= scan_i_reg + 1'b1;
            if (scan_e != it_id)
            begin
                keep_k_reg <= keep_k_reg + 1'b1;
                if (!found_reg && scan_e != cand_act)
                    found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && scan_e != it_id && !found_reg && scan_e != cand_act)
            cand_reg <= scan_e;
    end

    // Squared distances and thresholds.
    assign pdx = 17'(it_x) - 17'(prs_x_reg);
    assign pdy = 17'(it_y) - 17'(prs_y_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            sqa_reg  <= 34'($signed(34'(pdx)) * $signed(34'(pdx)));
            sqb_reg  <= 34'($signed(34'(pdy)) * $signed(34'(pdy)));
            thr2_reg <= 24'(thr_reg) * 24'(thr_reg);
            vx2_reg  <= 48'($signed(48'(vel_x_reg)) * $signed(48'(vel_x_reg)));
            vy2_reg  <= 48'($signed(48'(vel_y_reg)) * $signed(48'(vel_y_reg)));
            m2_reg   <= 48'({flick_reg, 8'd0}) * 48'({flick_reg, 8'd0});
        end
        if (cmd.cmp)
        begin
            near_reg <= (35'(sqa_reg) + 35'(sqb_reg)) <= 35'(thr2_reg);
            fast_reg <= (49'(vx2_reg) + 49'(vy2_reg)) >= 49'(m2_reg);
        end
    end

    // Velocity: restoring divider for |d|*256000 / (dt+1), then blend by 115/256.
    assign dsel    = cmd.axis ? (17'(act_y_reg) - 17'(lup_y_reg))
                              : (17'(act_x_reg) - 17'(lup_x_reg));
    assign dmag    = dsel[16] ? 17'(-dsel) : 17'(dsel);
    assign rem_sh  = {rem_reg, num_reg[34]};
    assign rem_ge  = rem_sh >= 34'(dvs_reg);
    assign vel_sel = cmd.axis ? vel_y_reg : vel_x_reg;

    always_comb
    begin
        if (!neg_reg && num_reg > 35'd8388607)
            inst = 25'sd8388607;
        else if (neg_reg && num_reg > 35'd8388608)
            inst = -25'sd8388608;
        else if (neg_reg)
            inst = -$signed(25'(num_reg));
        else
            inst = $signed(25'(num_reg));
    end

    assign vsum = 25'(vel_sel) + 25'(prod_reg >>> 8);

    always_comb
    begin
        if (vsum > 25'sd8388607)
            vnew = 24'sh7FFFFF;
        else if (vsum < -25'sd8388608)
            vnew = 24'sh800000;
        else
            vnew = vsum[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.dload)
        begin
            num_reg <= 35'(dmag) * VEL_SCALE;
            neg_reg <= dsel[16];
            rem_reg <= '0;
            dvs_reg <= 33'(it_now - upd_t_reg) + 33'd1;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? 33'(rem_sh - 34'(dvs_reg)) : rem_sh[32:0];
            num_reg <= {num_reg[33:0], rem_ge};
        end
        if (cmd.dblend)
            prod_reg <= 32'((32'(inst) - 32'(vel_sel)) * $signed({25'd0, VEL_ALPHA}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
        else if (cmd.dfin)
        begin
            if (cmd.axis)
                vel_y_reg <= vnew;
            else
                vel_x_reg <= vnew;
        end
        else if (cmd.exec && vel_clr)
        begin
            vel_x_reg <= '0;
            vel_y_reg <= '0;
        end
    end

    // Event decision: next state and results in one pass.
    always_comb
    begin
        logic [1:0]  n;
        logic [31:0] dt_evt;
        logic [16:0] ax, ay;
        logic [7:0]  a;
        logic        push;
        res_t        r;

        mode_next = mode_reg;
        act_f_next = act_f_reg; sec_f_next = sec_f_reg;
        act_x_next = act_x_reg; act_y_next = act_y_reg;
        sec_x_next = sec_x_reg; sec_y_next = sec_y_reg;
        prs_x_next = prs_x_reg; prs_y_next = prs_y_reg;
        lup_x_next = lup_x_reg; lup_y_next = lup_y_reg;
        evt_t_next = evt_t_reg; upd_t_next = upd_t_reg;
        utv_next = utv_reg; dtap_next = dtap_reg; bp_next = bp_reg;
        cnt_next = cnt_reg;
        vel_clr = 1'b0;
        press_wr = 1'b0;
        n = '0;
        push = 1'b0;
        r = '0;
        stage_nx[0] = '0; stage_nx[1] = '0; stage_nx[2] = '0;
        dt_evt = it_now - evt_t_reg;
        ax = it_dx[15] ? 17'(-(17'(it_dx))) : 17'(it_dx);
        ay = it_dy[15] ? 17'(-(17'(it_dy))) : 17'(it_dy);
        a = (act_f_reg == NONE_ID) ? it_id : act_f_reg;

        unique case (it_kind)
            K_PRESS:
            begin
                if (cnt_reg < CNT_W'(MAX_FINGERS))
                begin
                    press_wr = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                if (mode_reg != M_PINCH)
                begin
                    if (act_f_reg == NONE_ID)
                    begin
                        act_f_next = it_id; act_x_next = it_x; act_y_next = it_y;
                        if (mode_reg == M_TAPPED && mask_reg[G_DTAP] &&
                            dt_evt <= 32'(dtap_win_reg) && near_reg)
                        begin
                            stage_nx[n] = mk_res(G_DTAP, it_x, it_y, '0, '0, '0, '0, '0, '0,
                                                 it_id, NONE_ID);
                            n = n + 2'd1;
                            dtap_next = 1'b1;
                        end
                        mode_next = M_HOLDING;
                        prs_x_next = it_x; prs_y_next = it_y;
                        evt_t_next = it_now;
                    end
                    else if (mask_reg[G_PINCH])
                    begin
                        sec_f_next = it_id; sec_x_next = it_x; sec_y_next = it_y;
                        mode_next = M_PINCH;
                    end
                end
            end
            K_RELEASE:
            begin
                cnt_next = keep_k_reg;
                if (mode_reg == M_PINCH)
                begin
                    if (it_id == act_f_reg || it_id == sec_f_reg)
                    begin
                        if (mask_reg[G_PINCHDONE])
                        begin
                            stage_nx[n] = mk_res(G_PINCHDONE, '0, '0, '0, '0, '0, '0, '0, '0,
                                                 act_f_reg, sec_f_reg);
                            n = n + 2'd1;
                        end
                        if (it_id == act_f_reg)
                        begin
                            act_f_next = sec_f_reg; act_x_next = sec_x_reg;
                            act_y_next = sec_y_reg;
                        end
                        sec_f_next = found_reg ? cand_reg : NONE_ID;
                        if (!found_reg)
                            mode_next = M_HELD;
                    end
                end
                else
                begin
                    if (it_id == act_f_reg)
                        act_f_next = NONE_ID;
                    if (keep_k_reg == '0)
                    begin
                        if (mode_reg == M_HOLDING && (mask_reg[G_TAP] || mask_reg[G_DTAP]) &&
                            dt_evt < 32'(hold_reg) && !dtap_reg)
                        begin
                            if (mask_reg[G_TAP])
                            begin
                                stage_nx[n] = mk_res(G_TAP, it_x, it_y, '0, '0, '0, '0, '0,
                                                     '0, it_id, NONE_ID);
                                n = n + 2'd1;
                            end
                            mode_next = M_TAPPED;
                        end
                        dtap_next = 1'b0;
                        if (mask_reg[G_FLICK])
                        begin
                            if (!near_reg && fast_reg)
                            begin
                                stage_nx[n] = mk_res(G_FLICK, '0, '0, '0, '0,
                                                     vel_x_reg[23:8], vel_y_reg[23:8],
                                                     '0, '0, it_id, NONE_ID);
                                n = n + 2'd1;
                            end
                            vel_clr = 1'b1;
                            lup_x_next = '0; lup_y_next = '0;
                            upd_t_next = '0; utv_next = 1'b0;
                        end
                        if (mask_reg[G_DRAGDONE] && (mode_next == M_HORIZ ||
                            mode_next == M_VERT || mode_next == M_FREE))
                        begin
                            stage_nx[n] = mk_res(G_DRAGDONE, '0, '0, '0, '0, '0, '0, '0, '0,
                                                 it_id, NONE_ID);
                            n = n + 2'd1;
                        end
                        if (bp_reg && mask_reg[G_PINCHDONE] && n != 2'd3)
                        begin
                            stage_nx[n] = mk_res(G_PINCHDONE, '0, '0, '0, '0, '0, '0, '0,
                                                 '0, NONE_ID, NONE_ID);
                            n = n + 2'd1;
                        end
                        bp_next = 1'b0;
                        if (mode_next != M_TAPPED)
                            mode_next = M_NONE;
                        evt_t_next = it_now;
                    end
                end
            end
            K_MOVE:
            begin
                if (mode_reg == M_PINCH)
                begin
                    if (it_id == act_f_reg)
                    begin
                        act_x_next = it_x; act_y_next = it_y;
                        stage_nx[n] = mk_res(G_PINCH, it_x, it_y, sec_x_reg, sec_y_reg,
                                             it_dx, it_dy, '0, '0, act_f_reg, sec_f_reg);
                        n = n + 2'd1;
                    end
                    else if (it_id == sec_f_reg)
                    begin
                        sec_x_next = it_x; sec_y_next = it_y;
                        stage_nx[n] = mk_res(G_PINCH, act_x_reg, act_y_reg, it_x, it_y,
                                             '0, '0, it_dx, it_dy, act_f_reg, sec_f_reg);
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    act_f_next = a;
                    if (it_id == a)
                    begin
                        act_x_next = it_x; act_y_next = it_y;
                        if ((mode_reg == M_HOLDING || mode_reg == M_HELD) && !near_reg)
                        begin
                            if (mask_reg[G_HDRAG] && ax > ay)
                                mode_next = M_HORIZ;
                            else if (mask_reg[G_VDRAG] && ay > ax)
                                mode_next = M_VERT;
                            else if (mask_reg[G_FDRAG])
                                mode_next = M_FREE;
                            else
                                mode_next = M_NONE;
                        end
                        push = 1'b1;
                        if (mode_next == M_HORIZ && mask_reg[G_HDRAG])
                            r = mk_res(G_HDRAG, it_x, it_y, '0, '0, it_dx, '0, '0, '0,
                                       it_id, NONE_ID);
                        else if (mode_next == M_VERT && mask_reg[G_VDRAG])
                            r = mk_res(G_VDRAG, it_x, it_y, '0, '0, '0, it_dy, '0, '0,
                                       it_id, NONE_ID);
                        else if (mode_next == M_FREE && mask_reg[G_FDRAG])
                            r = mk_res(G_FDRAG, it_x, it_y, '0, '0, it_dx, it_dy, '0, '0,
                                       it_id, NONE_ID);
                        else
                            push = 1'b0;
                        if (push)
                        begin
                            stage_nx[n] = r;
                            n = n + 2'd1;
                        end
                        if ((mode_next == M_HORIZ && !mask_reg[G_HDRAG]) ||
                            (mode_next == M_VERT && !mask_reg[G_VDRAG]) ||
                            (mode_next == M_FREE && !mask_reg[G_FDRAG]))
                            mode_next = M_HELD;
                    end
                end
            end
            K_UPDATE:
            begin
                if (mode_reg == M_PINCH)
                begin
                    if (!mask_reg[G_PINCH])
                    begin
                        mode_next = M_HELD; sec_f_next = NONE_ID; bp_next = 1'b1;
                    end
                end
                else if (act_f_reg != NONE_ID)
                begin
                    if (mask_reg[G_FLICK])
                    begin
                        lup_x_next = act_x_reg; lup_y_next = act_y_reg;
                        upd_t_next = it_now; utv_next = 1'b1;
                    end
                    if (mask_reg[G_HOLD] && mode_reg == M_HOLDING &&
                        dt_evt >= 32'(hold_reg))
                    begin
                        stage_nx[n] = mk_res(G_HOLD, act_x_reg, act_y_reg, '0, '0, '0, '0,
                                             '0, '0, act_f_reg, NONE_ID);
                        n = n + 2'd1;
                        mode_next = M_HELD;
                    end
                end
            end
            default:
                mode_next = mode_reg;
        endcase
        stage_n_nx = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_NONE;
            act_f_reg <= NONE_ID; sec_f_reg <= NONE_ID;
            act_x_reg <= '0; act_y_reg <= '0; sec_x_reg <= '0; sec_y_reg <= '0;
            prs_x_reg <= '0; prs_y_reg <= '0; lup_x_reg <= '0; lup_y_reg <= '0;
            evt_t_reg <= '0; upd_t_reg <= '0;
            utv_reg <= 1'b0; dtap_reg <= 1'b0; bp_reg <= 1'b0;
            cnt_reg <= '0;
            stage_n_reg <= '0;
        end
        else if (cmd.exec)
        begin
            mode_reg <= mode_next;
            act_f_reg <= act_f_next; sec_f_reg <= sec_f_next;
            act_x_reg <= act_x_next; act_y_reg <= act_y_next;
            sec_x_reg <= sec_x_next; sec_y_reg <= sec_y_next;
            prs_x_reg <= prs_x_next; prs_y_reg <= prs_y_next;
            lup_x_reg <= lup_x_next; lup_y_reg <= lup_y_next;
            evt_t_reg <= evt_t_next; upd_t_reg <= upd_t_next;
            utv_reg <= utv_next; dtap_reg <= dtap_next; bp_reg <= bp_next;
            cnt_reg <= cnt_next;
            stage_n_reg <= stage_n_nx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stage_reg[0] <= stage_nx[0];
            stage_reg[1] <= stage_nx[1];
            stage_reg[2] <= stage_nx[2];
        end
    end

    // Output register: hold until taken, reload from staging on emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= stage_reg[cmd.emit_idx];
            out_reg.last <= cmd.emit_last;
        end
    end

endmodule

FILE: src/touch_gesture_recognizer_unit.sv
// Touch gesture recognizer top level: channel interfaces, controller and datapath.
// Depends on tgr_pkg, tgr_if, tgr_ctrl and tgr_dp.
//
// Usage: touch events (press, release, move, update tick) enter on evt; gestures
// leave on res, with last set on the final gesture of each event. Registers are
// written on cfg (index 0 enable mask, 1 move threshold, 2 double tap window,
// 3 hold time, 4 minimum flick speed); cfg is always ready. cfg is to be written
// only while the block is idle; the block itself does not enforce this.
// One event is handled at a time: the block scans the finger list on a release,
// compares distances and speeds, runs two passes of the 35-step serial divider
// (one per axis) on a tick that updates the flick velocity, updates its state
// and then emits each gesture in turn. evt.ready rises again once the last gesture
// has moved into the output register, so the next event is taken while that gesture
// still waits.
// A stalled receiver holds res steady and stops the block from loading the next
// gesture. Reset clears all gesture state and the finger count and restores the
// register defaults; the finger list holds no data until written.
module touch_gesture_recognizer_unit
    import tgr_pkg::*;
#(
    parameter int MAX_FINGERS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    tgr_evt_if.sink   evt,
    tgr_res_if.source res,
    tgr_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;
    res_t out_res;

    assign cfg.ready = 1'b1;

    tgr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tgr_dp #(
        .MAX_FINGERS (MAX_FINGERS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_kind   (evt.kind),
        .in_id     (evt.finger_id),
        .in_x      (evt.pos_x),
        .in_y      (evt.pos_y),
        .in_dx     (evt.delta_x),
        .in_dy     (evt.delta_y),
        .in_now    (evt.now_ms),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_res   (out_res)
    );

    assign res.gesture       = out_res.gesture;
    assign res.first_x       = out_res.fx;
    assign res.first_y       = out_res.fy;
    assign res.second_x      = out_res.sx;
    assign res.second_y      = out_res.sy;
    assign res.first_dx      = out_res.fdx;
    assign res.first_dy      = out_res.fdy;
    assign res.second_dx     = out_res.sdx;
    assign res.second_dy     = out_res.sdy;
    assign res.first_finger  = out_res.ff;
    assign res.second_finger = out_res.sf;
    assign res.last          = out_res.last;

endmodule
